// ===== hw/rtl/ecu_pkg.sv =====
// shared types and constants of the easing curve unit
// opcodes, curve kinds, bounce segment tables and the pipeline payload structs
// no dependencies
package ecu_pkg;

  // curve select codes as they arrive on the request channel
  localparam logic [4:0] OP_LINEAR       = 5'd0;
  localparam logic [4:0] OP_QUAD_IN      = 5'd1;
  localparam logic [4:0] OP_QUAD_OUT     = 5'd2;
  localparam logic [4:0] OP_QUAD_INOUT   = 5'd3;
  localparam logic [4:0] OP_CUBIC_IN     = 5'd4;
  localparam logic [4:0] OP_CUBIC_OUT    = 5'd5;
  localparam logic [4:0] OP_CUBIC_INOUT  = 5'd6;
  localparam logic [4:0] OP_QUART_IN     = 5'd7;
  localparam logic [4:0] OP_QUART_OUT    = 5'd8;
  localparam logic [4:0] OP_QUART_INOUT  = 5'd9;
  localparam logic [4:0] OP_QUINT_IN     = 5'd10;
  localparam logic [4:0] OP_QUINT_OUT    = 5'd11;
  localparam logic [4:0] OP_QUINT_INOUT  = 5'd12;
  localparam logic [4:0] OP_BACK_IN      = 5'd13;
  localparam logic [4:0] OP_BACK_OUT     = 5'd14;
  localparam logic [4:0] OP_BOUNCE_IN    = 5'd15;
  localparam logic [4:0] OP_BOUNCE_OUT   = 5'd16;
  localparam logic [4:0] OP_BOUNCE_INOUT = 5'd17;

  // polynomial degree, stored as degree minus two
  localparam logic [1:0] DEG_QUAD  = 2'd0;
  localparam logic [1:0] DEG_CUBIC = 2'd1;
  localparam logic [1:0] DEG_QUART = 2'd2;
  localparam logic [1:0] DEG_QUINT = 2'd3;

  typedef enum logic [3:0] {
    KIND_NONE,
    KIND_LINEAR,
    KIND_POLY_IN,
    KIND_POLY_OUT,
    KIND_POLY_INOUT,
    KIND_BACK_IN,
    KIND_BACK_OUT,
    KIND_BOUNCE_IN,
    KIND_BOUNCE_OUT,
    KIND_BOUNCE_INOUT
  } kind_e;

  // q16.16 constants
  localparam logic [16:0] FX_ONE      = 17'h10000;
  localparam logic [16:0] FX_HALF     = 17'h08000;
  localparam logic [17:0] BACK_C1_RST = 18'h1b39b;
  localparam logic [18:0] BACK_C3_RST = 19'h2b39b;

  // bounce: n1, d1, segment edges and offsets k/d1, rounded to nearest
  localparam logic signed [20:0] BNC_N1 = 21'sd495608;
  localparam longint BNC_D1_L  = 64'h2bffd;
  localparam longint FX_ONE_L  = 64'h10000;
  localparam longint BNC_K1_L  = 64'h18000;
  localparam longint BNC_K2_L  = 64'h24000;
  localparam longint BNC_K3_L  = 64'h2a000;
  localparam longint BNC_E1_L  = 64'h10000;
  localparam longint BNC_E2_L  = 64'h20000;
  localparam longint BNC_E3_L  = 64'h28000;

  localparam logic [16:0] BNC_KOFF1 = 17'((BNC_K1_L * FX_ONE_L + BNC_D1_L / 2) / BNC_D1_L);
  localparam logic [16:0] BNC_KOFF2 = 17'((BNC_K2_L * FX_ONE_L + BNC_D1_L / 2) / BNC_D1_L);
  localparam logic [16:0] BNC_KOFF3 = 17'((BNC_K3_L * FX_ONE_L + BNC_D1_L / 2) / BNC_D1_L);

  // d1*b >> 16 < e  is the same as  b < ceil(e * 2^16 / d1)
  localparam logic [16:0] BNC_T1 = 17'((BNC_E1_L * FX_ONE_L + BNC_D1_L - 1) / BNC_D1_L);
  localparam logic [16:0] BNC_T2 = 17'((BNC_E2_L * FX_ONE_L + BNC_D1_L - 1) / BNC_D1_L);
  localparam logic [16:0] BNC_T3 = 17'((BNC_E3_L * FX_ONE_L + BNC_D1_L - 1) / BNC_D1_L);

  localparam logic [15:0] BNC_C1 = 16'hc000;
  localparam logic [15:0] BNC_C2 = 16'hf000;
  localparam logic [15:0] BNC_C3 = 16'hfc00;

  // output range
  localparam logic signed [23:0] VAL_ONE = 24'sd65536;
  localparam logic signed [23:0] OUT_MIN = -24'sd131072;
  localparam logic signed [23:0] OUT_MAX = 24'sd196608;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  deg_m2;
    logic        lo_half;
    logic [16:0] t;
  } ctl_t;

  typedef struct packed {
    ctl_t               ctl;
    logic signed [17:0] x;
  } prep_t;

  typedef struct packed {
    ctl_t               ctl;
    logic signed [20:0] main_v;
    logic signed [18:0] q;
    logic [15:0]        c;
  } prod_t;

endpackage

// ===== hw/rtl/easing_curve_unit.sv =====
// easing curve unit, top level: stream ports, overshoot register, stage chain
// uses ecu_pkg, ecu_prep, ecu_mul, ecu_finish
//
// usage
// - one request on the s_axis channel carries the curve select in tuser and the
//   q16.16 progress in tdata; progress above 1.0 is treated as 1.0
// - one result leaves on the m_axis channel per request, in request order:
//   the signed q16.16 eased value in tdata and a clip flag in tuser
// - cfg_data_i writes the back overshoot c1 (q16.16); c1 + 1.0 is kept
//   alongside it; write only while no request is in flight
// - five register stages: clamp/decode, square, second product, third
//   product, combine/saturate
// - throughput one request per clock unless the sink stalls; every stage is fully pipelined
// - each stage holds its own valid bit and takes new data whenever it is empty
//   or its successor moves, so bubbles close up; when the sink holds tready low
//   the result register keeps its value and upstream stages keep filling until
//   all five are full, then s_axis_tready drops
// - reset clears all valid bits and restores c1 to 1.70158; cfg_ready_o is
//   always high
module easing_curve_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] t_in, rest ignored
  input  logic [4:0]  s_axis_tuser,   // [4:0] opcode
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [18:0] eased_value, [23:19] zero
  output logic        m_axis_tuser,   // [0] saturated
  // overshoot register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [17:0] cfg_data_i
);

  logic [17:0]    c1_q;
  logic [18:0]    c3_q;

  logic           prep_valid;
  logic           prep_ready;
  ecu_pkg::prep_t prep_data;
  logic           mul_valid;
  logic           mul_ready;
  ecu_pkg::prod_t mul_data;
  logic [18:0]    value;

  // config register, c3 = c1 + 1.0 kept ready for the back curves
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= ecu_pkg::BACK_C1_RST;
      c3_q <= ecu_pkg::BACK_C3_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      c1_q <= cfg_data_i;
      c3_q <= {1'b0, cfg_data_i} + {2'b00, ecu_pkg::FX_ONE};
    end
  end

  // stage 1: clamp, decode, operand
  ecu_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .opcode_i (s_axis_tuser),
    .t_in_i   (s_axis_tdata[16:0]),
    .valid_o  (prep_valid),
    .ready_i  (prep_ready),
    .data_o   (prep_data)
  );

  // stages 2 to 4: product chain
  ecu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .c1_i    (c1_q),
    .c3_i    (c3_q),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .data_o  (mul_data)
  );

  // stage 5: combine, saturate, result register
  ecu_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .data_i  (mul_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .value_o (value),
    .sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {5'b00000, value};

`ifndef NO_ASSERTIONS
  // a clipped result sits exactly on one of the range limits
  a_sat_on_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata[18:0] == ecu_pkg::OUT_MIN[18:0]) ||
       (m_axis_tdata[18:0] == ecu_pkg::OUT_MAX[18:0])))
    else $error("clipped result not on a range limit");

  // a write updates c1 and keeps c3 one above it
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=>
      ((c1_q == $past(cfg_data_i)) &&
       (c3_q == ({1'b0, $past(cfg_data_i)} + {2'b00, ecu_pkg::FX_ONE}))))
    else $error("overshoot register write lost");

  // requests are refused only when the sink is holding a result back
  a_stall_from_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("request channel stalled without sink back-pressure");
`endif

endmodule

// ===== hw/rtl/ecu_prep.sv =====
// first pipeline stage: clamp of progress, opcode decode, operand forming
// uses ecu_pkg
module ecu_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [4:0]     opcode_i,
  input  logic [16:0]    t_in_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ecu_pkg::prep_t data_o
);

  localparam logic signed [18:0] ONE_S = 19'sd65536;
  localparam logic signed [18:0] TWO_S = 19'sd131072;

  logic [16:0]           t_clamp;
  logic                  lo;
  logic signed [18:0]    t_s;
  logic signed [18:0]    x_w;
  ecu_pkg::kind_e        kind;
  logic [1:0]            deg_m2;
  ecu_pkg::prep_t        data_d;
  ecu_pkg::prep_t        data_q;
  logic                  valid_q;

  assign t_clamp = (t_in_i > ecu_pkg::FX_ONE) ? ecu_pkg::FX_ONE : t_in_i;
  assign lo      = t_clamp < ecu_pkg::FX_HALF;
  assign t_s     = $signed({2'b00, t_clamp});

  always_comb begin
    unique case (opcode_i)
      ecu_pkg::OP_LINEAR: kind = ecu_pkg::KIND_LINEAR;
      ecu_pkg::OP_QUAD_IN, ecu_pkg::OP_CUBIC_IN,
      ecu_pkg::OP_QUART_IN, ecu_pkg::OP_QUINT_IN: kind = ecu_pkg::KIND_POLY_IN;
      ecu_pkg::OP_QUAD_OUT, ecu_pkg::OP_CUBIC_OUT,
      ecu_pkg::OP_QUART_OUT, ecu_pkg::OP_QUINT_OUT: kind = ecu_pkg::KIND_POLY_OUT;
      ecu_pkg::OP_QUAD_INOUT, ecu_pkg::OP_CUBIC_INOUT,
      ecu_pkg::OP_QUART_INOUT, ecu_pkg::OP_QUINT_INOUT: kind = ecu_pkg::KIND_POLY_INOUT;
      ecu_pkg::OP_BACK_IN: kind = ecu_pkg::KIND_BACK_IN;
      ecu_pkg::OP_BACK_OUT: kind = ecu_pkg::KIND_BACK_OUT;
      ecu_pkg::OP_BOUNCE_IN: kind = ecu_pkg::KIND_BOUNCE_IN;
      ecu_pkg::OP_BOUNCE_OUT: kind = ecu_pkg::KIND_BOUNCE_OUT;
      ecu_pkg::OP_BOUNCE_INOUT: kind = ecu_pkg::KIND_BOUNCE_INOUT;
      default: kind = ecu_pkg::KIND_NONE;
    endcase
  end

  always_comb begin
    unique case (opcode_i)
      ecu_pkg::OP_CUBIC_IN, ecu_pkg::OP_CUBIC_OUT,
      ecu_pkg::OP_CUBIC_INOUT: deg_m2 = ecu_pkg::DEG_CUBIC;
      ecu_pkg::OP_QUART_IN, ecu_pkg::OP_QUART_OUT,
      ecu_pkg::OP_QUART_INOUT: deg_m2 = ecu_pkg::DEG_QUART;
      ecu_pkg::OP_QUINT_IN, ecu_pkg::OP_QUINT_OUT,
      ecu_pkg::OP_QUINT_INOUT: deg_m2 = ecu_pkg::DEG_QUINT;
      default: deg_m2 = ecu_pkg::DEG_QUAD;
    endcase
  end

  // operand of the power chain, or bounce argument, always within -1..1
  always_comb begin
    unique case (kind)
      ecu_pkg::KIND_POLY_OUT,
      ecu_pkg::KIND_BOUNCE_IN: x_w = ONE_S - t_s;
      ecu_pkg::KIND_POLY_INOUT: x_w = lo ? t_s : TWO_S - (t_s <<< 1);
      ecu_pkg::KIND_BACK_OUT: x_w = t_s - ONE_S;
      ecu_pkg::KIND_BOUNCE_INOUT: x_w = lo ? ONE_S - (t_s <<< 1) : (t_s <<< 1) - ONE_S;
      default: x_w = t_s;
    endcase
  end

  always_comb begin
    data_d.ctl.kind    = kind;
    data_d.ctl.deg_m2  = deg_m2;
    data_d.ctl.lo_half = lo;
    data_d.ctl.t       = t_clamp;
    data_d.x           = x_w[17:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/ecu_mul.sv =====
// three multiplier stages: squares and bounce segment, second and third products
// uses ecu_pkg
module ecu_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [17:0]    c1_i,
  input  logic [18:0]    c3_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  ecu_pkg::prep_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ecu_pkg::prod_t data_o
);

  function automatic logic is_poly(input ecu_pkg::kind_e k);
    is_poly = (k == ecu_pkg::KIND_POLY_IN) || (k == ecu_pkg::KIND_POLY_OUT) ||
              (k == ecu_pkg::KIND_POLY_INOUT);
  endfunction

  function automatic logic is_bounce(input ecu_pkg::kind_e k);
    is_bounce = (k == ecu_pkg::KIND_BOUNCE_IN) || (k == ecu_pkg::KIND_BOUNCE_OUT) ||
                (k == ecu_pkg::KIND_BOUNCE_INOUT);
  endfunction

  // stage 2: x squared, bounce segment and offset
  logic [16:0]        b2;
  logic signed [35:0] sq2;
  logic signed [17:0] m1;
  logic signed [17:0] s2;
  logic [16:0]        koff;
  logic [15:0]        cseg;
  logic               v2_q;
  ecu_pkg::ctl_t      ctl2_q;
  logic signed [17:0] x2_q;
  logic signed [17:0] w2_q;
  logic [15:0]        c2_q;
  logic               rdy2;

  // stage 3: second product and c1 term
  logic signed [19:0] a3;
  logic signed [37:0] prod_a;
  logic signed [36:0] prod_b;
  logic signed [19:0] p3;
  logic               v3_q;
  ecu_pkg::ctl_t      ctl3_q;
  logic signed [17:0] x3_q;
  logic signed [19:0] p3_q;
  logic signed [18:0] q3_q;
  logic [15:0]        c3s_q;
  logic               rdy3;

  // stage 4: third product
  logic signed [20:0] a4;
  logic signed [40:0] prod4;
  logic signed [20:0] main4;
  logic               v4_q;
  ecu_pkg::prod_t     out_q;
  logic               rdy4;

  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;

  assign b2  = data_i.x[16:0];
  assign sq2 = $signed(data_i.x) * $signed(data_i.x);
  assign m1  = sq2[33:16];

  always_comb begin
    priority if (b2 < ecu_pkg::BNC_T1) begin
      koff = '0;
      cseg = '0;
    end else if (b2 < ecu_pkg::BNC_T2) begin
      koff = ecu_pkg::BNC_KOFF1;
      cseg = ecu_pkg::BNC_C1;
    end else if (b2 < ecu_pkg::BNC_T3) begin
      koff = ecu_pkg::BNC_KOFF2;
      cseg = ecu_pkg::BNC_C2;
    end else begin
      koff = ecu_pkg::BNC_KOFF3;
      cseg = ecu_pkg::BNC_C3;
    end
  end

  assign s2 = $signed({1'b0, b2}) - $signed({1'b0, koff});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && valid_i) begin
      ctl2_q <= data_i.ctl;
      x2_q   <= data_i.x;
      w2_q   <= is_bounce(data_i.ctl.kind) ? s2 : m1;
      c2_q   <= cseg;
    end
  end

  // cubic and back out take x, back in takes c3, the rest square w
  always_comb begin
    if ((is_poly(ctl2_q.kind) && (ctl2_q.deg_m2 == ecu_pkg::DEG_CUBIC)) ||
        (ctl2_q.kind == ecu_pkg::KIND_BACK_OUT)) begin
      a3 = {{2{x2_q[17]}}, x2_q};
    end else if (ctl2_q.kind == ecu_pkg::KIND_BACK_IN) begin
      a3 = $signed({1'b0, c3_i});
    end else begin
      a3 = {{2{w2_q[17]}}, w2_q};
    end
  end

  assign prod_a = a3 * w2_q;
  assign prod_b = $signed({1'b0, c1_i}) * w2_q;
  assign p3 = (is_poly(ctl2_q.kind) && (ctl2_q.deg_m2 == ecu_pkg::DEG_QUAD)) ?
              {{2{w2_q[17]}}, w2_q} : prod_a[35:16];

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      ctl3_q <= ctl2_q;
      x3_q   <= x2_q;
      p3_q   <= p3;
      q3_q   <= prod_b[34:16];
      c3s_q  <= c2_q;
    end
  end

  always_comb begin
    unique case (ctl3_q.kind)
      ecu_pkg::KIND_BACK_IN: a4 = $signed({4'b0000, ctl3_q.t});
      ecu_pkg::KIND_BACK_OUT: a4 = $signed({2'b00, c3_i});
      ecu_pkg::KIND_BOUNCE_IN, ecu_pkg::KIND_BOUNCE_OUT,
      ecu_pkg::KIND_BOUNCE_INOUT: a4 = ecu_pkg::BNC_N1;
      default: a4 = {{3{x3_q[17]}}, x3_q};
    endcase
  end

  assign prod4 = a4 * p3_q;
  assign main4 = (is_poly(ctl3_q.kind) && (ctl3_q.deg_m2 != ecu_pkg::DEG_QUINT)) ?
                 {p3_q[19], p3_q} : prod4[36:16];

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_q.ctl    <= ctl3_q;
      out_q.main_v <= main4;
      out_q.q      <= q3_q;
      out_q.c      <= c3s_q;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = out_q;

endmodule

// ===== hw/rtl/ecu_finish.sv =====
// last stage: per-curve combination of the products, saturation, result register
// uses ecu_pkg
module ecu_finish (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  ecu_pkg::prod_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [18:0]    value_o,
  output logic           sat_o
);

  logic signed [23:0] main_w;
  logic signed [23:0] q_w;
  logic signed [23:0] rb_w;
  logic signed [23:0] pw_sh;
  logic signed [23:0] v_w;
  logic [2:0]         shamt;
  logic [18:0]        value_d;
  logic               sat_d;
  logic               valid_q;
  logic [18:0]        value_q;
  logic               sat_q;

  assign main_w = {{3{data_i.main_v[20]}}, data_i.main_v};
  assign q_w    = {{5{data_i.q[18]}}, data_i.q};
  assign rb_w   = main_w + $signed({8'h00, data_i.c});
  assign shamt  = {1'b0, data_i.ctl.deg_m2} + 3'd1;
  assign pw_sh  = main_w <<< shamt;

  always_comb begin
    unique case (data_i.ctl.kind)
      ecu_pkg::KIND_LINEAR: v_w = $signed({7'b0, data_i.ctl.t});
      ecu_pkg::KIND_POLY_IN: v_w = main_w;
      ecu_pkg::KIND_POLY_OUT: v_w = ecu_pkg::VAL_ONE - main_w;
      ecu_pkg::KIND_POLY_INOUT:
        v_w = data_i.ctl.lo_half ? pw_sh : ecu_pkg::VAL_ONE - (main_w >>> 1);
      ecu_pkg::KIND_BACK_IN: v_w = main_w - q_w;
      ecu_pkg::KIND_BACK_OUT: v_w = ecu_pkg::VAL_ONE + main_w + q_w;
      ecu_pkg::KIND_BOUNCE_IN: v_w = ecu_pkg::VAL_ONE - rb_w;
      ecu_pkg::KIND_BOUNCE_OUT: v_w = rb_w;
      ecu_pkg::KIND_BOUNCE_INOUT:
        v_w = data_i.ctl.lo_half ? (ecu_pkg::VAL_ONE - rb_w) >>> 1
                                 : (ecu_pkg::VAL_ONE + rb_w) >>> 1;
      default: v_w = '0;
    endcase
  end

  always_comb begin
    priority if (v_w < ecu_pkg::OUT_MIN) begin
      value_d = ecu_pkg::OUT_MIN[18:0];
      sat_d   = 1'b1;
    end else if (v_w > ecu_pkg::OUT_MAX) begin
      value_d = ecu_pkg::OUT_MAX[18:0];
      sat_d   = 1'b1;
    end else begin
      value_d = v_w[18:0];
      sat_d   = 1'b0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign sat_o   = sat_q;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for easing_curve_unit: stream requests in, eased results out
// predicts every result from its own q16.16 curve arithmetic; depends on ecu_pkg
`timescale 1ns / 1ps

module testbench;

  // q16.16 arithmetic constants of the curves
  localparam longint Q_ONE      = 64'd65536;
  localparam longint Q_HALF     = 64'd32768;
  localparam longint BNC_SCALE  = 64'h78ff8;   // n1
  localparam longint BNC_DIV    = 64'h2bffd;   // d1
  localparam longint BNC_EDGE3  = 64'h28000;   // 2.5
  localparam longint BNC_K1     = 64'h18000;
  localparam longint BNC_K2     = 64'h24000;
  localparam longint BNC_K3     = 64'h2a000;
  localparam longint BNC_LIFT1  = 64'hc000;
  localparam longint BNC_LIFT2  = 64'hf000;
  localparam longint BNC_LIFT3  = 64'hfc00;
  localparam longint VAL_FLOOR  = -64'sd131072;
  localparam longint VAL_CEIL   = 64'sd196608;

  localparam logic [17:0] OVERSHOOT_RESET = 18'd111515;
  localparam logic [17:0] OVERSHOOT_MAX   = 18'h3FFFF;
  localparam logic [4:0]  OP_FIRST_UNUSED = ecu_pkg::OP_BOUNCE_INOUT + 5'd1;
  localparam logic [4:0]  OP_LAST_CODE    = 5'h1F;
  localparam logic [16:0] T_MAX           = 17'h1FFFF;

  localparam int PIPE_DEPTH     = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 200;

  typedef struct {
    logic [4:0]         op;
    logic [16:0]        t_raw;
    logic signed [18:0] value;
    logic               clipped;
  } eased_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [17:0] cfg_data_i = '0;

  // model state: overshoot copy and results still to come back
  logic [17:0] overshoot = OVERSHOOT_RESET;
  eased_req_t  eased_in_flight[$];

  bit no_idle = 1'b0;
  int errors = 0;
  int stall_cycles = 0;
  int req_count = 0;
  int result_count = 0;
  int clip_count = 0;
  int unused_count = 0;
  int cfg_writes = 0;

  easing_curve_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // curve arithmetic: signed products, floor shift by 16
  // ---------------------------------------------------------------------------
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint poly_pow(longint t, int deg);
    longint t2;
    t2 = fx_mul(t, t);
    case (deg)
      2: return t2;
      3: return fx_mul(t, t2);
      4: return fx_mul(t2, t2);
      default: return fx_mul(t, fx_mul(t2, t2));
    endcase
  endfunction

  // k/d1 rounded to nearest
  function automatic longint bounce_offset(longint k);
    return (k * Q_ONE + BNC_DIV / 2) / BNC_DIV;
  endfunction

  // smallest progress whose d1 product reaches the segment edge
  function automatic longint bounce_edge(longint e);
    return (e * Q_ONE + BNC_DIV - 1) / BNC_DIV;
  endfunction

  function automatic longint bounce_out(longint t);
    longint d;
    longint s;
    longint lift;
    d = fx_mul(BNC_DIV, t);
    if (d < Q_ONE) return fx_mul(BNC_SCALE, fx_mul(t, t));
    if (d < 2 * Q_ONE) begin
      s = t - bounce_offset(BNC_K1);
      lift = BNC_LIFT1;
    end else if (d < BNC_EDGE3) begin
      s = t - bounce_offset(BNC_K2);
      lift = BNC_LIFT2;
    end else begin
      s = t - bounce_offset(BNC_K3);
      lift = BNC_LIFT3;
    end
    return fx_mul(BNC_SCALE, fx_mul(s, s)) + lift;
  endfunction

  function automatic longint ease_curve(logic [4:0] op, longint t, longint c1);
    longint c3;
    longint u;
    longint u2;
    int deg;
    c3 = c1 + Q_ONE;
    deg = 2 + (int'(op) - int'(ecu_pkg::OP_QUAD_IN)) / 3;
    case (op)
      ecu_pkg::OP_LINEAR: return t;
      ecu_pkg::OP_QUAD_IN, ecu_pkg::OP_CUBIC_IN,
      ecu_pkg::OP_QUART_IN, ecu_pkg::OP_QUINT_IN:
        return poly_pow(t, deg);
      ecu_pkg::OP_QUAD_OUT, ecu_pkg::OP_CUBIC_OUT,
      ecu_pkg::OP_QUART_OUT, ecu_pkg::OP_QUINT_OUT:
        return Q_ONE - poly_pow(Q_ONE - t, deg);
      ecu_pkg::OP_QUAD_INOUT, ecu_pkg::OP_CUBIC_INOUT,
      ecu_pkg::OP_QUART_INOUT, ecu_pkg::OP_QUINT_INOUT: begin
        if (t < Q_HALF) return poly_pow(t, deg) * (longint'(1) << (deg - 1));
        return Q_ONE - (poly_pow(2 * Q_ONE - 2 * t, deg) >>> 1);
      end
      ecu_pkg::OP_BACK_IN: begin
        u2 = fx_mul(t, t);
        return fx_mul(fx_mul(c3, u2), t) - fx_mul(c1, u2);
      end
      ecu_pkg::OP_BACK_OUT: begin
        u = t - Q_ONE;
        u2 = fx_mul(u, u);
        return Q_ONE + fx_mul(c3, fx_mul(u, u2)) + fx_mul(c1, u2);
      end
      ecu_pkg::OP_BOUNCE_IN: return Q_ONE - bounce_out(Q_ONE - t);
      ecu_pkg::OP_BOUNCE_OUT: return bounce_out(t);
      ecu_pkg::OP_BOUNCE_INOUT: begin
        if (t < Q_HALF) return (Q_ONE - bounce_out(Q_ONE - 2 * t)) >>> 1;
        return (Q_ONE + bounce_out(2 * t - Q_ONE)) >>> 1;
      end
      default: return 0;
    endcase
  endfunction

  // clamp progress, evaluate, saturate to the output range
  function automatic eased_req_t eased_result(logic [4:0] op, logic [16:0] t_raw,
                                              logic [17:0] c1);
    eased_req_t r;
    longint t;
    longint v;
    t = (t_raw > Q_ONE) ? Q_ONE : longint'(t_raw);
    v = ease_curve(op, t, longint'(c1));
    r.op = op;
    r.t_raw = t_raw;
    r.clipped = 1'b0;
    if (v < VAL_FLOOR) begin
      v = VAL_FLOOR;
      r.clipped = 1'b1;
    end else if (v > VAL_CEIL) begin
      v = VAL_CEIL;
      r.clipped = 1'b1;
    end
    r.value = v[18:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: register writes, requests and results, all sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    eased_req_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        result_count++;
        if (eased_in_flight.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with no request outstanding, tdata %h tuser %b",
                     $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = eased_in_flight.pop_front();
          if (want.clipped) clip_count++;
          if (m_axis_tdata[18:0] !== want.value) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: eased_value op %0d t %h: expected %0d actual %0d",
                       $time, want.op, want.t_raw, want.value,
                       $signed(m_axis_tdata[18:0]));
          end
          if (m_axis_tdata[23:19] !== 5'd0) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: tdata padding op %0d t %h: expected 0 actual %h",
                       $time, want.op, want.t_raw, m_axis_tdata[23:19]);
          end
          if (m_axis_tuser !== want.clipped) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: saturated op %0d t %h: expected %b actual %b",
                       $time, want.op, want.t_raw, want.clipped, m_axis_tuser);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        req_count++;
        if (s_axis_tuser > ecu_pkg::OP_BOUNCE_INOUT) unused_count++;
        eased_in_flight.push_back(eased_result(s_axis_tuser, s_axis_tdata[16:0],
                                               overshoot));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        cfg_writes++;
        overshoot = cfg_data_i;
      end
      // watchdog: too long without any handshake
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, eased_in_flight.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // sink back-pressure, off during the no-idle stretch
  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 12);
  end

  // ---------------------------------------------------------------------------
  // drivers, entered and left at the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [4:0] op, logic [16:0] t);
    while (!no_idle && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, t};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // every result back, then let the stages settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (eased_in_flight.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH) @(negedge clk_i);
  endtask

  task automatic set_idling(bit off);
    @(posedge clk_i);
    no_idle = off;
    @(negedge clk_i);
  endtask

  function automatic logic [4:0] rand_curve(int back_pct);
    int r;
    r = $urandom_range(99);
    if (r < back_pct)
      return 5'($urandom_range(ecu_pkg::OP_BACK_OUT, ecu_pkg::OP_BACK_IN));
    if (r < back_pct + 8) return 5'($urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED));
    return 5'($urandom_range(ecu_pkg::OP_BOUNCE_INOUT));
  endfunction

  function automatic logic [16:0] rand_progress();
    longint p;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(7))
          0: p = 0;
          1: p = 1;
          2: p = Q_HALF - 1;
          3: p = Q_HALF;
          4: p = Q_ONE - 1;
          5: p = Q_ONE;
          6: p = Q_ONE + 1;
          default: p = T_MAX;
        endcase
      end
      1: p = $urandom_range(T_MAX, Q_ONE + 1);
      2: begin
        // around a bounce segment edge, mirrored for the in and in-out forms
        case ($urandom_range(2))
          0: p = bounce_edge(Q_ONE);
          1: p = bounce_edge(2 * Q_ONE);
          default: p = bounce_edge(BNC_EDGE3);
        endcase
        p = p + int'($urandom_range(4)) - 2;
        case ($urandom_range(3))
          0: p = p;
          1: p = Q_ONE - p;
          2: p = p / 2;
          default: p = (Q_ONE + p) / 2;
        endcase
      end
      default: p = $urandom_range(Q_ONE);
    endcase
    return p[16:0];
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_corners();
    logic [16:0] corners [5];
    corners[0] = 17'd0;
    corners[1] = 17'(Q_ONE);
    corners[2] = T_MAX;
    corners[3] = 17'(Q_HALF);
    corners[4] = 17'(Q_HALF - 1);
    // every curve at one of the corner progress values (ends, above 1.0, around 0.5)
    for (int op = ecu_pkg::OP_LINEAR; op <= ecu_pkg::OP_BOUNCE_INOUT; op++)
      send_request(5'(op), corners[op % 5]);
    // unused codes give zero
    send_request(OP_FIRST_UNUSED, 17'(Q_HALF));
    send_request(OP_LAST_CODE, T_MAX);
    // either side of each bounce segment edge
    send_request(ecu_pkg::OP_BOUNCE_OUT, 17'(bounce_edge(Q_ONE) - 1));
    send_request(ecu_pkg::OP_BOUNCE_OUT, 17'(bounce_edge(Q_ONE)));
    send_request(ecu_pkg::OP_BOUNCE_OUT, 17'(bounce_edge(2 * Q_ONE) - 1));
    send_request(ecu_pkg::OP_BOUNCE_OUT, 17'(bounce_edge(2 * Q_ONE)));
    send_request(ecu_pkg::OP_BOUNCE_OUT, 17'(bounce_edge(BNC_EDGE3) - 1));
    send_request(ecu_pkg::OP_BOUNCE_OUT, 17'(bounce_edge(BNC_EDGE3)));
    wait_idle();
  endtask

  task automatic test_random_curves(int n);
    repeat (n) send_request(rand_curve(12), rand_progress());
    wait_idle();
  endtask

  task automatic test_back_to_back(int n);
    set_idling(1'b1);
    repeat (n) send_request(rand_curve(12), rand_progress());
    wait_idle();
    set_idling(1'b0);
  endtask

  // new overshoot while idle, then a run weighted towards the back curves
  task automatic test_overshoot(logic [17:0] c1, int n);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    repeat (n) send_request(rand_curve(50), rand_progress());
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_corners();
    test_random_curves(400);
    test_back_to_back(200);
    test_overshoot(18'd0, 200);
    test_overshoot(OVERSHOOT_MAX, 200);
    test_overshoot(18'($urandom_range(OVERSHOOT_MAX)), 200);
    test_overshoot(OVERSHOOT_RESET, 200);
    test_random_curves(230);

    $display("covered %0d requests over curve codes 0..31 (%0d on unused codes), %0d results",
             req_count, unused_count, result_count);
    $display("overshoot written %0d times incl. zero and full scale, %0d results clipped",
             cfg_writes, clip_count);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
